### sv/gbq_pkg.sv
// ----------------------------------------------------------------------------
// gbq_pkg
// Shared constants, widths and types for the beam parameter transform.
// ----------------------------------------------------------------------------
package gbq_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;

    // signed sums such as A*qr + B*2^F
    localparam int VAL_BITS  = 2 * WORD_BITS + 1;
    // magnitude of a signed sum
    localparam int MAG_BITS  = VAL_BITS;
    // full product of two magnitudes
    localparam int PROD_BITS = 2 * MAG_BITS;
    // signed numerator of one output part
    localparam int NUM_BITS  = PROD_BITS + 2;
    // divider remainder and shifted divisor
    localparam int REM_BITS  = PROD_BITS + 3 + WORD_BITS + FRACTION_BITS;

    localparam logic [WORD_BITS-1:0] ONE_FIXED = WORD_BITS'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2,
        REG_D = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    // one quotient lane travelling along the divider cells
    typedef struct packed {
        logic                 vld;
        logic                 neg;
        logic                 ovf;
        logic                 zero;
        logic [REM_BITS-1:0]  rem;
        logic [REM_BITS-1:0]  dsh;
        logic [WORD_BITS-1:0] quo;
    } div_lane_t;

endpackage

### sv/gaussian_beam_q_transform.sv
// ----------------------------------------------------------------------------
// gaussian_beam_q_transform
// ABCD law on a complex beam parameter, q' = (A*q + B) / (C*q + D).
// ----------------------------------------------------------------------------
// a request runs through the front stages, the divider and the done register
// throughput: one request per cycle, busy is never raised
// real and imaginary dividers are each a row of WORD_BITS cells, one quotient bit per cell
// reset: matrix goes to identity, all pipeline valid bits clear
// results are shown for one cycle on done, the receiver cannot stall
module gaussian_beam_q_transform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_in_real,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_in_imag,
    output logic                                done,
    output logic signed [gbq_pkg::WORD_BITS-1:0] q_out_real,
    output logic signed [gbq_pkg::WORD_BITS-1:0] q_out_imag,
    output logic [1:0]                          status,
    input  logic                                wr_en,
    input  logic [1:0]                          wr_index,
    input  logic [gbq_pkg::WORD_BITS-1:0]       wr_data
);
    import gbq_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int PV = 8;

    logic signed [W-1:0] matrix_a_reg, matrix_b_reg, matrix_c_reg, matrix_d_reg;
    logic [PV-1:0]       vld_reg;
    logic [PV-1:0]       vld_next;

    // stage 1: products with q
    logic signed [2*W-1:0] aqr_reg, aqi_reg, cqr_reg, cqi_reg;
    // stage 2: signed numerator and denominator parts
    logic signed [VAL_BITS-1:0] nr_reg, ni_reg, dr_reg, di_reg;
    // stage 3: magnitudes and signs
    logic [MAG_BITS-1:0] nr_mag_reg, ni_mag_reg, dr_mag_reg, di_mag_reg;
    logic [3:0]          sgn3_reg, sgn4_reg, sgn5_reg, sgn6_reg;
    // stage 7: combined products
    logic [PROD_BITS-1:0] p_rr, p_ii, p_ir, p_ri, p_dd, p_ee;
    logic signed [NUM_BITS-1:0] re_num_reg, im_num_reg;
    logic [PROD_BITS:0]         den7_reg;
    // stage 8: magnitudes of numerators
    logic [NUM_BITS-1:0] re_mag_reg, im_mag_reg;
    logic                re_neg_reg, im_neg_reg, zero8_reg;
    logic [PROD_BITS:0]  den8_reg;

    div_lane_t chain_re [W+1];
    div_lane_t chain_im [W+1];
    div_lane_t entry_re_next, entry_im_next;
    div_lane_t entry_re_reg, entry_im_reg;

    logic signed [W-1:0] q_out_real_reg, q_out_imag_reg;
    logic signed [W-1:0] q_out_real_next, q_out_imag_next;
    logic [1:0]          status_reg, status_next;
    logic                done_reg;
    logic [W:0]          sat_re, sat_im;

    function automatic logic [MAG_BITS-1:0] abs_val(input logic signed [VAL_BITS-1:0] v);
        logic signed [VAL_BITS-1:0] n;
        n = -v;
        return v[VAL_BITS-1] ? MAG_BITS'(n) : MAG_BITS'(v);
    endfunction

    function automatic logic signed [NUM_BITS-1:0] signed_prod(
        input logic [PROD_BITS-1:0] p, input logic neg);
        logic signed [NUM_BITS-1:0] t;
        t = $signed(NUM_BITS'(p));
        return neg ? -t : t;
    endfunction

    // {sat, value}
    function automatic logic [W:0] saturate(input logic [W-1:0] quo, input logic neg,
                                            input logic ovf);
        logic [W-1:0] half;
        logic         sat;
        logic [W-1:0] val;
        half = {1'b1, {(W-1){1'b0}}};
        if (neg)
        begin
            sat = ovf || (quo > half);
            val = sat ? half : (~quo + W'(1));
        end
        else
        begin
            sat = ovf || quo[W-1];
            val = sat ? ~half : quo;
        end
        return {sat, val};
    endfunction

    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_a_reg <= ONE_FIXED;
            matrix_b_reg <= '0;
            matrix_c_reg <= '0;
            matrix_d_reg <= ONE_FIXED;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_A:   matrix_a_reg <= wr_data;
                REG_B:   matrix_b_reg <= wr_data;
                REG_C:   matrix_c_reg <= wr_data;
                REG_D:   matrix_d_reg <= wr_data;
                default: matrix_a_reg <= matrix_a_reg;
            endcase
        end
    end

    assign vld_next = {vld_reg[PV-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // front stages, no reset on payload
    always_ff @(posedge clk)
    begin
        aqr_reg <= matrix_a_reg * q_in_real;
        aqi_reg <= matrix_a_reg * q_in_imag;
        cqr_reg <= matrix_c_reg * q_in_real;
        cqi_reg <= matrix_c_reg * q_in_imag;

        nr_reg <= VAL_BITS'(aqr_reg) + (VAL_BITS'(matrix_b_reg) <<< F);
        ni_reg <= VAL_BITS'(aqi_reg);
        dr_reg <= VAL_BITS'(cqr_reg) + (VAL_BITS'(matrix_d_reg) <<< F);
        di_reg <= VAL_BITS'(cqi_reg);

        nr_mag_reg <= abs_val(nr_reg);
        ni_mag_reg <= abs_val(ni_reg);
        dr_mag_reg <= abs_val(dr_reg);
        di_mag_reg <= abs_val(di_reg);
        // {nr, ni, dr, di}
        sgn3_reg <= {nr_reg[VAL_BITS-1], ni_reg[VAL_BITS-1],
                     dr_reg[VAL_BITS-1], di_reg[VAL_BITS-1]};
        sgn4_reg <= sgn3_reg;
        sgn5_reg <= sgn4_reg;
        sgn6_reg <= sgn5_reg;

        re_num_reg <= signed_prod(p_rr, sgn6_reg[3] ^ sgn6_reg[1])
                    + signed_prod(p_ii, sgn6_reg[2] ^ sgn6_reg[0]);
        im_num_reg <= signed_prod(p_ir, sgn6_reg[2] ^ sgn6_reg[1])
                    - signed_prod(p_ri, sgn6_reg[3] ^ sgn6_reg[0]);
        den7_reg   <= (PROD_BITS+1)'(p_dd) + (PROD_BITS+1)'(p_ee);

        re_neg_reg <= re_num_reg[NUM_BITS-1];
        im_neg_reg <= im_num_reg[NUM_BITS-1];
        re_mag_reg <= re_num_reg[NUM_BITS-1] ? NUM_BITS'(-re_num_reg) : NUM_BITS'(re_num_reg);
        im_mag_reg <= im_num_reg[NUM_BITS-1] ? NUM_BITS'(-im_num_reg) : NUM_BITS'(im_num_reg);
        den8_reg   <= den7_reg;
        zero8_reg  <= (den7_reg == '0);
    end

    gbq_wmul u_mul_rr (.clk(clk), .a(nr_mag_reg), .b(dr_mag_reg), .p(p_rr));
    gbq_wmul u_mul_ii (.clk(clk), .a(ni_mag_reg), .b(di_mag_reg), .p(p_ii));
    gbq_wmul u_mul_ir (.clk(clk), .a(ni_mag_reg), .b(dr_mag_reg), .p(p_ir));
    gbq_wmul u_mul_ri (.clk(clk), .a(nr_mag_reg), .b(di_mag_reg), .p(p_ri));
    gbq_wmul u_mul_dd (.clk(clk), .a(dr_mag_reg), .b(dr_mag_reg), .p(p_dd));
    gbq_wmul u_mul_ee (.clk(clk), .a(di_mag_reg), .b(di_mag_reg), .p(p_ee));

    // divider entry: scale numerator, align divisor, catch quotients past W bits
    always_comb
    begin
        entry_re_next.vld  = vld_reg[PV-1];
        entry_re_next.zero = zero8_reg;
        entry_re_next.neg  = re_neg_reg;
        entry_re_next.rem  = REM_BITS'(re_mag_reg) << F;
        entry_re_next.dsh  = REM_BITS'(den8_reg) << (W - 1);
        entry_re_next.ovf  = entry_re_next.rem >= (REM_BITS'(den8_reg) << W);
        entry_re_next.quo  = '0;

        entry_im_next.vld  = vld_reg[PV-1];
        entry_im_next.zero = zero8_reg;
        entry_im_next.neg  = im_neg_reg;
        entry_im_next.rem  = REM_BITS'(im_mag_reg) << F;
        entry_im_next.dsh  = REM_BITS'(den8_reg) << (W - 1);
        entry_im_next.ovf  = entry_im_next.rem >= (REM_BITS'(den8_reg) << W);
        entry_im_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_re_reg.vld <= 1'b0;
            entry_im_reg.vld <= 1'b0;
        end
        else
        begin
            entry_re_reg <= entry_re_next;
            entry_im_reg <= entry_im_next;
        end
    end

    assign chain_re[0] = entry_re_reg;
    assign chain_im[0] = entry_im_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_cells
        gbq_div_cell u_cell_re (
            .clk(clk), .rst_n(rst_n), .lane_in(chain_re[i]), .lane_out(chain_re[i+1]));
        gbq_div_cell u_cell_im (
            .clk(clk), .rst_n(rst_n), .lane_in(chain_im[i]), .lane_out(chain_im[i+1]));
    end

    always_comb
    begin
        sat_re = saturate(chain_re[W].quo, chain_re[W].neg, chain_re[W].ovf);
        sat_im = saturate(chain_im[W].quo, chain_im[W].neg, chain_im[W].ovf);
        if (chain_re[W].zero)
        begin
            q_out_real_next = '0;
            q_out_imag_next = '0;
            status_next     = STATUS_ZERO;
        end
        else
        begin
            q_out_real_next = sat_re[W-1:0];
            q_out_imag_next = sat_im[W-1:0];
            status_next     = (sat_re[W] | sat_im[W]) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_re[W].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        q_out_real_reg <= q_out_real_next;
        q_out_imag_reg <= q_out_imag_next;
        status_reg     <= status_next;
    end

    assign done       = done_reg;
    assign q_out_real = q_out_real_reg;
    assign q_out_imag = q_out_imag_reg;
    assign status     = status_reg;

endmodule

### sv/gbq_wmul.sv
// ----------------------------------------------------------------------------
// gbq_wmul
// Unsigned magnitude multiplier, split in halves over three register stages.
// ----------------------------------------------------------------------------
module gbq_wmul (
    input  logic                          clk,
    input  logic [gbq_pkg::MAG_BITS-1:0]  a,
    input  logic [gbq_pkg::MAG_BITS-1:0]  b,
    output logic [gbq_pkg::PROD_BITS-1:0] p
);
    import gbq_pkg::*;

    localparam int LB = (MAG_BITS + 1) / 2;
    localparam int HB = MAG_BITS - LB;

    logic [2*LB-1:0]    ll_reg;
    logic [LB+HB-1:0]   lh_reg;
    logic [LB+HB-1:0]   hl_reg;
    logic [2*HB-1:0]    hh_reg;
    logic [LB+HB:0]     mid_reg;
    logic [PROD_BITS-1:0] cat_reg;
    logic [PROD_BITS-1:0] p_reg;

    logic [LB+HB:0]     mid_next;
    logic [PROD_BITS-1:0] cat_next;
    logic [PROD_BITS-1:0] p_next;

    always_comb
    begin
        mid_next = (LB+HB+1)'(lh_reg) + (LB+HB+1)'(hl_reg);
        cat_next = {hh_reg, ll_reg};
        p_next   = cat_reg + (PROD_BITS'(mid_reg) << LB);
    end

    always_ff @(posedge clk)
    begin
        ll_reg  <= a[LB-1:0] * b[LB-1:0];
        lh_reg  <= a[LB-1:0] * b[MAG_BITS-1:LB];
        hl_reg  <= a[MAG_BITS-1:LB] * b[LB-1:0];
        hh_reg  <= a[MAG_BITS-1:LB] * b[MAG_BITS-1:LB];
        mid_reg <= mid_next;
        cat_reg <= cat_next;
        p_reg   <= p_next;
    end

    assign p = p_reg;

endmodule

### sv/gbq_div_cell.sv
// ----------------------------------------------------------------------------
// gbq_div_cell
// One restoring division cell: settles one quotient bit and passes on.
// ----------------------------------------------------------------------------
module gbq_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  gbq_pkg::div_lane_t lane_in,
    output gbq_pkg::div_lane_t lane_out
);
    import gbq_pkg::*;

    div_lane_t lane_reg;
    div_lane_t lane_next;
    logic      ge;

    always_comb
    begin
        ge             = lane_in.rem >= lane_in.dsh;
        lane_next      = lane_in;
        lane_next.rem  = ge ? (lane_in.rem - lane_in.dsh) : lane_in.rem;
        lane_next.dsh  = lane_in.dsh >> 1;
        lane_next.quo  = {lane_in.quo[WORD_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.vld <= 1'b0;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### bench/beam_q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_q_checker
// Watches the request, result and matrix write ports of the ABCD transform,
// works out each transformed beam parameter exactly and compares results.
// ----------------------------------------------------------------------------
module beam_q_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_in_real,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_in_imag,
    input  logic                                 done,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_out_real,
    input  logic signed [gbq_pkg::WORD_BITS-1:0] q_out_imag,
    input  logic [1:0]                           status,
    input  logic                                 wr_en,
    input  logic [1:0]                           wr_index,
    input  logic [gbq_pkg::WORD_BITS-1:0]        wr_data,
    output int                                   fail_count,
    output int                                   pending
);
    import gbq_pkg::*;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
        status_t                     st;
    } beam_q_t;

    typedef logic signed [255:0] big_t;

    beam_q_t q_expected[$];
    logic signed [WORD_BITS-1:0] mat_a, mat_b, mat_c, mat_d;

    // exact (num * 2^F) / den toward zero, clamped to the word
    function automatic logic signed [WORD_BITS-1:0] clamp_quotient(
        big_t num, big_t den, inout logic sat);
        big_t q;
        big_t hi;
        big_t lo;
        hi = (big_t'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -(big_t'(1) <<< (WORD_BITS - 1));
        q = (num <<< FRACTION_BITS) / den;
        if (q > hi)
        begin
            sat = 1'b1;
            return hi[WORD_BITS-1:0];
        end
        if (q < lo)
        begin
            sat = 1'b1;
            return lo[WORD_BITS-1:0];
        end
        return q[WORD_BITS-1:0];
    endfunction

    function automatic beam_q_t transform_q(logic signed [WORD_BITS-1:0] qr_w,
                                            logic signed [WORD_BITS-1:0] qi_w);
        big_t qr, qi, nr, ni, dr, di, den;
        beam_q_t r;
        logic sat;
        qr = qr_w;
        qi = qi_w;
        sat = 1'b0;
        nr = big_t'(mat_a) * qr + (big_t'(mat_b) <<< FRACTION_BITS);
        ni = big_t'(mat_a) * qi;
        dr = big_t'(mat_c) * qr + (big_t'(mat_d) <<< FRACTION_BITS);
        di = big_t'(mat_c) * qi;
        den = dr * dr + di * di;
        if (den == 0)
        begin
            r.re = '0;
            r.im = '0;
            r.st = STATUS_ZERO;
            return r;
        end
        r.re = clamp_quotient(nr * dr + ni * di, den, sat);
        r.im = clamp_quotient(ni * dr - nr * di, den, sat);
        r.st = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        beam_q_t e;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            mat_a <= ONE_FIXED;
            mat_b <= '0;
            mat_c <= '0;
            mat_d <= ONE_FIXED;
            fail_count <= 0;
            pending <= 0;
            q_expected.delete();
        end
        else
        begin
            if (done)
            begin
                if (q_expected.size() == 0)
                begin
                    $error("result with no request waiting");
                    errs++;
                end
                else
                begin
                    e = q_expected.pop_front();
                    if (q_out_real !== e.re)
                    begin
                        $error("q_out_real expected %0d actual %0d", e.re, q_out_real);
                        errs++;
                    end
                    if (q_out_imag !== e.im)
                    begin
                        $error("q_out_imag expected %0d actual %0d", e.im, q_out_imag);
                        errs++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        errs++;
                    end
                end
            end
            // user must change registers only while idle; nothing enforces it
            if (start && !busy)
                q_expected.push_back(transform_q(q_in_real, q_in_imag));
            if (wr_en)
            begin
                case (reg_index_t'(wr_index))
                    REG_A:   mat_a <= wr_data;
                    REG_B:   mat_b <= wr_data;
                    REG_C:   mat_c <= wr_data;
                    REG_D:   mat_d <= wr_data;
                    default: ;
                endcase
            end
            fail_count <= fail_count + errs;
            pending <= q_expected.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ABCD beam parameter transform: directed corners, then
// random requests, several matrices, mostly with random gaps; then a verdict.
// ----------------------------------------------------------------------------
module tb;
    import gbq_pkg::*;

    localparam int LATENCY     = WORD_BITS + 10;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [WORD_BITS-1:0] q_in_real;
    logic signed [WORD_BITS-1:0] q_in_imag;
    logic done;
    logic signed [WORD_BITS-1:0] q_out_real;
    logic signed [WORD_BITS-1:0] q_out_imag;
    logic [1:0] status;
    logic wr_en;
    logic [1:0] wr_index;
    logic [WORD_BITS-1:0] wr_data;
    int fail_count;
    int pending;
    int cycles = 0;

    gaussian_beam_q_transform dut (.*);

    beam_q_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(WORD_BITS-1){1'b1}}};
            1: return {1'b1, {(WORD_BITS-1){1'b0}}};
            2: return '0;
            3: return ONE_FIXED;
            4: return -ONE_FIXED;
            5, 6: return WORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // one request, holding start across back-to-back requests
    task automatic send_q(logic [WORD_BITS-1:0] re, logic [WORD_BITS-1:0] im, bit gaps);
        int gap;
        start <= 1'b1;
        q_in_real <= re;
        q_in_imag <= im;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(reg_index_t idx, logic [WORD_BITS-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
    endtask

    task automatic load_matrix(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                               logic [WORD_BITS-1:0] c, logic [WORD_BITS-1:0] d);
        write_reg(REG_A, a);
        write_reg(REG_B, b);
        write_reg(REG_C, c);
        write_reg(REG_D, d);
        wr_en <= 1'b0;
    endtask

    localparam logic [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        q_in_real = '0;
        q_in_imag = '0;
        wr_en = 1'b0;
        wr_index = REG_A;
        wr_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity matrix from reset: corners of q
        send_q('0, '0, 0);
        send_q(MAXW, MAXW, 0);
        send_q(MINW, MINW, 0);
        send_q(ONE_FIXED, -ONE_FIXED, 0);
        send_q(32'h0001_8000, 32'h0002_0000, 0);
        drain();
        // A = D = 1, B = 3, C = -0.5
        load_matrix(ONE_FIXED, 32'h0003_0000, 32'hFFFF_8000, ONE_FIXED);
        send_q(32'h0000_4000, 32'h0001_0000, 0);
        send_q('0, ONE_FIXED, 0);
        send_q(MAXW, 32'h0000_0001, 0);
        drain();
        // C = 0, D = 0: every denominator is zero
        load_matrix(MINW, MAXW, '0, '0);
        send_q(ONE_FIXED, ONE_FIXED, 0);
        send_q(MAXW, MINW, 0);
        drain();
        // zero denominator only where C*q = -D, and huge quotients
        load_matrix(MAXW, MAXW, ONE_FIXED, -ONE_FIXED);
        send_q(ONE_FIXED, '0, 0);
        send_q(32'h0001_0001, '0, 0);
        send_q(ONE_FIXED, 32'h0000_0001, 0);
        send_q(MINW, MAXW, 0);
        drain();
        load_matrix(MAXW, MINW, MINW, MAXW);
        send_q(MAXW, '0, 0);
        send_q('0, MINW, 0);
        send_q(32'hFFFF_FFFF, 32'h0000_0001, 0);
        drain();

        // random phases, each under its own matrix
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                load_matrix(ONE_FIXED, '0, '0, ONE_FIXED);
            else
                load_matrix(rand_word(), rand_word(), rand_word(), rand_word());
            for (int i = 0; i < 85; i++)
            begin
                send_q(rand_word(), rand_word(), ph != 4);
                // hold off once, in one phase, until the pipeline is empty
                if (i == 40 && ph == 2)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
sv/gbq_pkg.sv
sv/gbq_wmul.sv
sv/gbq_div_cell.sv
sv/gaussian_beam_q_transform.sv
bench/beam_q_checker.sv
bench/tb.sv
